/* hw/rtl/sukset_pkg.sv */
// Shared types and codes for the sorted unique key set.
package sukset_pkg;

  localparam int KEY_W      = 32;
  localparam int POS_W      = 7;
  localparam int CAPACITY_D = 64;

  // Request codes; the unused code behaves as a find
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_SPARE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT_UP,
    S_SHIFT_DN,
    S_PUT,
    S_RESP
  } fsm_t;

  typedef struct packed {
    logic [1:0]        req_type;
    logic signed [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic [POS_W-1:0] count;
    logic [1:0]       status;
  } out_word_t;

endpackage

/* hw/rtl/sukset_ram.sv */
// Key store: one write port, one registered read port.
module sukset_ram
  import sukset_pkg::*;
#(
  parameter int DEPTH = CAPACITY_D,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [KEY_W-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [KEY_W-1:0] rd_data
);

  logic [KEY_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, registered
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* hw/rtl/sorted_unique_key_set.sv */
// Sorted unique key set: linear scan of a key memory, then a shift by one entry where
// an insert or remove needs one. Steps: the scan up to pos, then for an insert a shift
// of any entries from pos up and a key write, or for a remove a shift down of the
// entries above pos, then a response. One word in flight; the next is taken the cycle
// after the result registers. The key memory has a single port pair.
// Reset (rst_n low, synchronous) empties the set; memory contents are not cleared.
module sorted_unique_key_set
  import sukset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_D
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
  localparam logic [CW-1:0] ONE_C = CW'(1);
  localparam logic [CW-1:0] TWO_C = CW'(2);

  fsm_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  req_t req_r, req_nxt;
  logic found_r, found_nxt;
  status_t status_r, status_nxt;
  logic out_valid_r, out_valid_nxt;
  out_word_t out_r, out_nxt;

  logic             wr_en;
  logic [CW-1:0]    wr_addr_w;
  logic [KEY_W-1:0] wr_data;
  logic [CW-1:0]    rd_addr_w;
  logic [KEY_W-1:0] rd_data;

  logic scan_stop, scan_hit;
  logic [CW+POS_W-1:0] pos_ext, cnt_ext;

  sukset_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr_w[AW-1:0]),
    .wr_data (wr_data),
    .rd_addr (rd_addr_w[AW-1:0]),
    .rd_data (rd_data)
  );

  // scan compare on the entry at idx_r
  assign scan_hit  = (idx_r < cnt_r) && (rd_data == key_r);
  assign scan_stop = (idx_r >= cnt_r) || ($signed(rd_data) >= $signed(key_r));

  assign pos_ext = {{POS_W{1'b0}}, pos_r};
  assign cnt_ext = {{POS_W{1'b0}}, cnt_r};

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // next state, memory control and result
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    req_nxt       = req_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    wr_en         = 1'b0;
    wr_addr_w     = idx_r;
    wr_data       = rd_data;
    rd_addr_w     = '0;

    unique case (state_r)
      S_IDLE: begin
        rd_addr_w = '0;
        if (in_valid) begin
          key_nxt   = in_data.key;
          req_nxt   = req_t'(in_data.req_type);
          idx_nxt   = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        rd_addr_w = idx_r + ONE_C;
        if (!scan_stop) begin
          idx_nxt = idx_r + ONE_C;
        end else begin
          pos_nxt   = idx_r;
          found_nxt = scan_hit;
          state_nxt = S_RESP;
          priority case (req_r)
            REQ_INSERT: begin
              if (scan_hit) begin
                status_nxt = ST_DUPLICATE;
              end else if (cnt_r >= CAP_C) begin
                status_nxt = ST_FULL;
              end else begin
                status_nxt = ST_DONE;
                cnt_nxt    = cnt_r + ONE_C;
                if (idx_r == cnt_r) begin
                  state_nxt = S_PUT;
                end else begin
                  // move the top entry first
                  rd_addr_w = cnt_r - ONE_C;
                  idx_nxt   = cnt_r;
                  state_nxt = S_SHIFT_UP;
                end
              end
            end
            REQ_REMOVE: begin
              if (scan_hit) begin
                status_nxt = ST_DONE;
                cnt_nxt    = cnt_r - ONE_C;
                if (idx_r + ONE_C < cnt_r) begin
                  rd_addr_w = idx_r + ONE_C;
                  state_nxt = S_SHIFT_DN;
                end
              end else begin
                status_nxt = ST_NOT_FOUND;
              end
            end
            default: begin
              status_nxt = scan_hit ? ST_DONE : ST_NOT_FOUND;
            end
          endcase
        end
      end

      // entries[idx] <= entries[idx-1], walking down to pos+1
      S_SHIFT_UP: begin
        wr_en     = 1'b1;
        wr_addr_w = idx_r;
        wr_data   = rd_data;
        rd_addr_w = idx_r - TWO_C;
        idx_nxt   = idx_r - ONE_C;
        if (idx_r - ONE_C == pos_r) begin
          state_nxt = S_PUT;
        end
      end

      // entries[idx] <= entries[idx+1], walking up to the new top
      S_SHIFT_DN: begin
        wr_en     = 1'b1;
        wr_addr_w = idx_r;
        wr_data   = rd_data;
        rd_addr_w = idx_r + TWO_C;
        idx_nxt   = idx_r + ONE_C;
        if (idx_r + ONE_C == cnt_r) begin
          state_nxt = S_RESP;
        end
      end

      S_PUT: begin
        wr_en     = 1'b1;
        wr_addr_w = pos_r;
        wr_data   = key_r;
        state_nxt = S_RESP;
      end

      // hand the result over once the output register is free
      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_nxt.found    = found_r;
          out_nxt.position = pos_ext[POS_W-1:0];
          out_nxt.count    = cnt_ext[POS_W-1:0];
          out_nxt.status   = status_r;
          state_nxt        = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and payload registers
  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    req_r    <= req_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    out_r    <= out_nxt;
  end

endmodule
